### hw/rtl/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared widths and sizes of the row correlation block.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int MAX_LEN     = 64;
  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int LEN_W       = 7;
  localparam int ACC_W       = 64;
  localparam int ROW_W       = 6;
  localparam int COEF_W      = 32;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [ADDR_W-1:0]      addr_t;

  typedef struct packed {
    logic    we;
    addr_t   waddr;
    sample_t wdata;
    logic    re;
    addr_t   raddr;
  } store_ctl_t;

endpackage

### hw/rtl/row_correlation_coefficients_top.sv
// ----------------------------------------------------------------------------
// row_correlation_coefficients_top
// Pearson coefficient of each matrix row against a stored reference vector.
// ----------------------------------------------------------------------------
// a vector beat writes the store and adds to its sums; a matrix beat reads the
// store, then uses the shared 24x24 multiplier twice; the beat that ends a row
// then runs six shift-add products, two normalize and root passes, the shift
// steps and a restoring divide, plus any wait for the previous result beat to
// be taken; no new beat is taken until then
// synchronous reset clears sums, counters and vec_len (64); store is unset
// ----------------------------------------------------------------------------
module row_correlation_coefficients_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic signed [rcc_pkg::SAMPLE_BITS-1:0] sample_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rcc_pkg::COEF_W-1:0]   coef,
  output logic [rcc_pkg::ROW_W-1:0]           row_index,
  output logic                                degenerate,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcc_pkg::LEN_W-1:0]           cfg_data
);

  localparam int AW = rcc_pkg::ACC_W;
  localparam int SB = rcc_pkg::SAMPLE_BITS;
  localparam int LW = rcc_pkg::LEN_W;
  localparam int COEF_W_L = rcc_pkg::COEF_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_CROSS = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_DMUL  = 4'd7;
  localparam logic [3:0] S_SHIFT = 4'd8;
  localparam logic [3:0] S_DIV0  = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  localparam logic [30:0] ONE = 31'h4000_0000;

  logic [3:0]        state;
  logic [LW-1:0]     vec_len;
  logic [LW-1:0]     n_eff;
  logic [LW-1:0]     element_pos;
  logic [LW-1:0]     pos_eff;
  logic [LW-1:0]     posr;
  logic [LW-1:0]     pos_inc;
  logic [rcc_pkg::ROW_W-1:0] current_row;
  logic [LW-1:0]     row_inc;
  logic              typ;
  logic [AW-1:0]     xr;
  logic [AW-1:0]     vector_sum, vector_sq_sum;
  logic [AW-1:0]     row_sum, row_sq_sum, cross_sum;

  rcc_pkg::store_ctl_t store_ctl;
  rcc_pkg::sample_t    store_rd;

  logic signed [SB-1:0]   mul_b;
  logic signed [2*SB-1:0] prod;
  logic [AW-1:0]          prod_ext;

  logic [AW-1:0] ma, mb, macc, mres, mt;
  logic [5:0]    mcnt;
  logic [2:0]    mjob, jsel;
  logic [AW-1:0] op_a, op_b;
  logic [AW-1:0] vx, vy, num;

  logic [AW-1:0]      sv, sres, sbit, strial, sres_new;
  logic [4:0]         scnt;
  logic signed [7:0]  se, ex;
  logic               ssel;
  logic [31:0]        rx;

  logic [AW-1:0]      d, m, rem, rem2;
  logic signed [7:0]  hcnt;
  logic signed [8:0]  hsum;
  logic [31:0]        q;
  logic [4:0]         dcnt;
  logic               neg, degen;
  logic [30:0]        cmag;
  logic [COEF_W_L-1:0] coef_val;

  always_comb begin
    if (vec_len < LW'(2)) begin
      n_eff = LW'(2);
    end else if (vec_len > LW'(rcc_pkg::MAX_LEN)) begin
      n_eff = LW'(rcc_pkg::MAX_LEN);
    end else begin
      n_eff = vec_len;
    end
  end

  assign pos_eff   = (element_pos >= n_eff) ? '0 : element_pos;
  assign pos_inc   = posr + LW'(1);
  assign row_inc   = {1'b0, current_row} + LW'(1);
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign store_ctl.we    = in_valid && in_ready && !req_type;
  assign store_ctl.waddr = pos_eff[rcc_pkg::ADDR_W-1:0];
  assign store_ctl.wdata = sample_value;
  assign store_ctl.re    = in_valid && in_ready && req_type;
  assign store_ctl.raddr = pos_eff[rcc_pkg::ADDR_W-1:0];

  rcc_vec_store u_store (
    .clk   (clk),
    .ctl   (store_ctl),
    .rdata (store_rd)
  );

  assign mul_b    = (state == S_CROSS) ? $signed(store_rd) : $signed(xr[SB-1:0]);
  assign prod     = $signed(xr[SB-1:0]) * mul_b;
  assign prod_ext = {{(AW-2*SB){prod[2*SB-1]}}, prod};

  assign mres = macc + (mb[0] ? ma : '0);
  assign jsel = (state == S_CROSS) ? 3'd0 : mjob + 3'd1;

  always_comb begin
    case (jsel)
      3'd0: begin
        op_a = AW'(n_eff);
        op_b = vector_sq_sum;
      end
      3'd1: begin
        op_a = vector_sum;
        op_b = vector_sum;
      end
      3'd2: begin
        op_a = AW'(n_eff);
        op_b = row_sq_sum;
      end
      3'd3: begin
        op_a = row_sum;
        op_b = row_sum;
      end
      3'd4: begin
        op_a = AW'(n_eff);
        op_b = cross_sum;
      end
      3'd5: begin
        op_a = vector_sum;
        op_b = row_sum;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign strial   = sres + sbit;
  assign sres_new = (sv >= strial) ? ((sres >> 1) + sbit) : (sres >> 1);
  assign hsum     = 9'(ex) + 9'(se);
  assign rem2     = {rem[AW-2:0], 1'b0};
  assign coef_val = neg ? -{1'b0, cmag} : {1'b0, cmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vec_len       <= LW'(rcc_pkg::MAX_LEN);
      element_pos   <= '0;
      current_row   <= '0;
      vector_sum    <= '0;
      vector_sq_sum <= '0;
      row_sum       <= '0;
      row_sq_sum    <= '0;
      cross_sum     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vec_len <= cfg_data;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            typ  <= req_type;
            xr   <= {{(AW-SB){sample_value[SB-1]}}, sample_value};
            posr <= pos_eff;
            if (pos_eff == '0) begin
              if (!req_type) begin
                vector_sum    <= '0;
                vector_sq_sum <= '0;
                current_row   <= '0;
              end else begin
                row_sum    <= '0;
                row_sq_sum <= '0;
                cross_sum  <= '0;
              end
            end
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (!typ) begin
            vector_sum    <= vector_sum + xr;
            vector_sq_sum <= vector_sq_sum + prod_ext;
            element_pos   <= (pos_inc >= n_eff) ? '0 : pos_inc;
            state         <= S_IDLE;
          end else begin
            row_sum    <= row_sum + xr;
            row_sq_sum <= row_sq_sum + prod_ext;
            state      <= S_CROSS;
          end
        end
        S_CROSS: begin
          cross_sum <= cross_sum + prod_ext;
          if (pos_inc < n_eff) begin
            element_pos <= pos_inc;
            state       <= S_IDLE;
          end else begin
            element_pos <= '0;
            mjob        <= 3'd0;
            ma          <= op_a;
            mb          <= op_b;
            macc        <= '0;
            mcnt        <= '0;
            state       <= S_MUL;
          end
        end
        S_MUL: begin
          if (mcnt != 6'd63) begin
            macc <= mres;
            ma   <= {ma[AW-2:0], 1'b0};
            mb   <= mb >> 1;
            mcnt <= mcnt + 6'd1;
          end else begin
            case (mjob)
              3'd1:    vx  <= mt - mres;
              3'd3:    vy  <= mt - mres;
              3'd5:    num <= mt - mres;
              default: mt  <= mres;
            endcase
            if (mjob == 3'd5) begin
              state <= S_CHECK;
            end else begin
              mjob <= jsel;
              ma   <= op_a;
              mb   <= op_b;
              macc <= '0;
              mcnt <= '0;
            end
          end
        end
        S_CHECK: begin
          if (vx == '0 || vx[AW-1] || vy == '0 || vy[AW-1]) begin
            degen <= 1'b1;
            neg   <= 1'b0;
            cmag  <= '0;
            state <= S_DONE;
          end else begin
            degen <= 1'b0;
            neg   <= num[AW-1];
            sv    <= vx;
            se    <= '0;
            ssel  <= 1'b0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (sv[AW-1:AW-2] != 2'b00) begin
            sv <= sv >> 2;
            se <= se - 8'sd2;
          end else if (sv[AW-1:AW-4] == 4'b0000) begin
            sv <= {sv[AW-3:0], 2'b00};
            se <= se + 8'sd2;
          end else begin
            sres  <= '0;
            sbit  <= AW'(1) << (AW-2);
            scnt  <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sv >= strial) begin
            sv <= sv - strial;
          end
          sres <= sres_new;
          sbit <= sbit >> 2;
          scnt <= scnt + 5'd1;
          if (scnt == 5'd31) begin
            if (!ssel) begin
              rx    <= sres_new[31:0];
              ex    <= se;
              sv    <= vy;
              se    <= '0;
              ssel  <= 1'b1;
              state <= S_NORM;
            end else begin
              sres  <= sres_new;
              state <= S_DMUL;
            end
          end
        end
        S_DMUL: begin
          d     <= {32'd0, rx} * {32'd0, sres[31:0]};
          hcnt  <= 8'(hsum >>> 1);
          m     <= neg ? -num : num;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (hcnt > 8'sd0) begin
            if (m[AW-1]) begin
              cmag  <= ONE;
              state <= S_DONE;
            end else begin
              m    <= {m[AW-2:0], 1'b0};
              hcnt <= hcnt - 8'sd1;
            end
          end else if (hcnt < 8'sd0) begin
            m    <= m >> 1;
            hcnt <= hcnt + 8'sd1;
          end else begin
            state <= S_DIV0;
          end
        end
        S_DIV0: begin
          if (m >= {d[AW-2:0], 1'b0}) begin
            cmag  <= ONE;
            state <= S_DONE;
          end else begin
            if (m >= d) begin
              q   <= 32'd1;
              rem <= m - d;
            end else begin
              q   <= 32'd0;
              rem <= m;
            end
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2 >= d) begin
            rem <= rem2 - d;
            q   <= {q[30:0], 1'b1};
          end else begin
            rem <= rem2;
            q   <= {q[30:0], 1'b0};
          end
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd29) begin
            state <= S_DONE;
            if ({q[30:0], (rem2 >= d)} > {1'b0, ONE}) begin
              cmag <= ONE;
            end else begin
              cmag <= {q[29:0], (rem2 >= d)};
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            coef       <= coef_val;
            row_index  <= current_row;
            degenerate <= degen;
            current_row <= (row_inc >= n_eff) ? '0 : row_inc[rcc_pkg::ROW_W-1:0];
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/rcc_vec_store.sv
// ----------------------------------------------------------------------------
// rcc_vec_store
// Reference vector memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rcc_vec_store (
  input  logic                clk,
  input  rcc_pkg::store_ctl_t ctl,
  output rcc_pkg::sample_t    rdata
);

  rcc_pkg::sample_t mem [rcc_pkg::MAX_LEN];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rdata <= mem[ctl.raddr];
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Loads reference vectors and matrix rows into the row correlation block
// under random idling on both sides, predicts each row's coefficient with an
// integer model of the sums, root and divide, and checks every result beat.
// ----------------------------------------------------------------------------
class corr_scoreboard;

  typedef struct {
    logic [31:0] coef;
    logic [5:0]  row;
    logic        degen;
  } corr_result_t;

  logic [63:0]  vstore [64];
  bit           written [64];
  logic [63:0]  vsum, vsq, rsum, rsq, xsum;
  int unsigned  pos, row, len;
  corr_result_t pending_q [$];
  int           errors;

  function new();
    vsum = 0; vsq = 0; rsum = 0; rsq = 0; xsum = 0;
    pos = 0; row = 0; len = 64; errors = 0;
    foreach (vstore[i]) begin
      vstore[i] = 0;
      written[i] = 0;
    end
  endfunction

  function int unsigned eff_len();
    if (len < 2) return 2;
    if (len > 64) return 64;
    return len;
  endfunction

  function int unsigned cur_pos();
    if (pos >= eff_len()) return 0;
    return pos;
  endfunction

  function void set_len(logic [6:0] v);
    len = 32'(v);
  endfunction

  function logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function logic [63:0] norm_root(logic [63:0] v, output int e);
    e = 0;
    while (v >= (64'd1 << 62)) begin
      v = v >> 2;
      e -= 2;
    end
    while (v < (64'd1 << 60)) begin
      v = v << 2;
      e += 2;
    end
    return isqrt(v);
  endfunction

  function logic [63:0] coef_mag(logic [63:0] mag, logic [63:0] vx, logic [63:0] vy);
    logic [63:0] one, rx, ry, d, m, q, rem;
    int ex, ey, h;
    one = 64'd1 << 30;
    rx = norm_root(vx, ex);
    ry = norm_root(vy, ey);
    d = rx * ry;
    h = (ex + ey) / 2;
    if (h >= 0) begin
      if (h >= 64 || mag > ({64{1'b1}} >> h)) return one;
      m = mag << h;
    end else begin
      m = (-h >= 64) ? 64'd0 : (mag >> (-h));
    end
    q = m / d;
    if (q >= 2) return one;
    rem = m % d;
    for (int i = 0; i < 30; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
    end
    return (q > one) ? one : q;
  endfunction

  function void note_beat(logic kind, logic [23:0] raw);
    logic [63:0] x, nn, vx, vy, num, mag, c;
    int unsigned n, p;
    corr_result_t r;
    n = eff_len();
    p = cur_pos();
    nn = 64'(n);
    x = {{40{raw[23]}}, raw};
    if (kind == 1'b0) begin
      if (p == 0) begin
        vsum = 0; vsq = 0; row = 0;
      end
      vstore[p] = x;
      written[p] = 1;
      vsum += x;
      vsq += x * x;
      p++;
      pos = (p >= n) ? 0 : p;
      return;
    end
    if (p == 0) begin
      rsum = 0; rsq = 0; xsum = 0;
    end
    rsum += x;
    rsq += x * x;
    xsum += x * vstore[p];
    p++;
    if (p < n) begin
      pos = p;
      return;
    end
    pos = 0;
    vx = nn * vsq - vsum * vsum;
    vy = nn * rsq - rsum * rsum;
    num = nn * xsum - vsum * rsum;
    if (vx == 0 || vx[63] || vy == 0 || vy[63]) begin
      r.coef = 0;
      r.degen = 1;
    end else begin
      mag = num[63] ? (64'd0 - num) : num;
      c = coef_mag(mag, vx, vy);
      c = num[63] ? (64'd0 - c) : c;
      r.coef = c[31:0];
      r.degen = 0;
    end
    r.row = row[5:0];
    pending_q.push_back(r);
    row++;
    if (row >= n) row = 0;
  endfunction

  function void check_beat(logic [31:0] coef, logic [5:0] rowi, logic degen);
    corr_result_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result beat coef=%h row=%0d degenerate=%b",
               $time, coef, rowi, degen);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (coef !== e.coef) begin
      $display("%0t: coef expected %h actual %h", $time, e.coef, coef);
      errors++;
    end
    if (rowi !== e.row) begin
      $display("%0t: row_index expected %0d actual %0d", $time, e.row, rowi);
      errors++;
    end
    if (degen !== e.degen) begin
      $display("%0t: degenerate expected %b actual %b", $time, e.degen, degen);
      errors++;
    end
  endfunction

endclass

module testbench;

  logic        clk, rst;
  logic        in_valid, in_ready, req_type;
  logic signed [rcc_pkg::SAMPLE_BITS-1:0] sample_value;
  logic        out_valid, out_ready;
  logic signed [rcc_pkg::COEF_W-1:0] coef;
  logic [rcc_pkg::ROW_W-1:0] row_index;
  logic        degenerate;
  logic        cfg_valid, cfg_ready;
  logic [rcc_pkg::LEN_W-1:0] cfg_data;

  corr_scoreboard sb;
  int send_idle_pct, recv_idle_pct, beats_sent;

  row_correlation_coefficients_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .sample_value(sample_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .coef(coef), .row_index(row_index), .degenerate(degenerate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_beat(coef, row_index, degenerate);
  end

  task automatic drive_sample(logic kind, logic [23:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    // a matrix beat must never read a vector entry that was never loaded
    if (kind && !sb.written[sb.cur_pos()]) kind = 1'b0;
    in_valid = 1;
    req_type = kind;
    sample_value = v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(kind, v);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (700) @(negedge clk);
  endtask

  task automatic write_len(logic [6:0] v);
    wait_drained();
    cfg_valid = 1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_len(v);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [23:0] row_value(int kind, logic [23:0] base);
    logic [23:0] cp;
    cp = sb.vstore[sb.cur_pos()][23:0];
    case (kind)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(511)) - 256);
      2: return base;
      3: return cp;
      4: return -cp;
      default: return cp + 24'($signed($urandom_range(15)) - 8);
    endcase
  endfunction

  task automatic random_part(int count);
    int stop, kind, n;
    logic [23:0] base;
    stop = beats_sent + count;
    while (beats_sent < stop) begin
      n = sb.eff_len();
      kind = $urandom_range(99);
      if (kind < 12) begin
        kind = $urandom_range(2);
        for (int i = 0; i < n; i++)
          drive_sample(1'b0, kind == 0 ? 24'($urandom) :
                             kind == 1 ? 24'($urandom_range(1023)) : 24'h5);
      end else if (kind < 20) begin
        drive_sample(1'($urandom_range(1)), 24'($urandom));
      end else if (kind < 22) begin
        wait_drained();
      end else begin
        kind = $urandom_range(5);
        base = 24'($urandom);
        for (int i = 0; i < n; i++) drive_sample(1'b1, row_value(kind, base));
      end
    end
  endtask

  initial begin
    logic [6:0] lens [8];
    sb = new();
    lens = '{7'd64, 7'd2, 7'd5, 7'd0, 7'd127, 7'd17, 7'd1, 7'd3};
    rst = 1; in_valid = 0; req_type = 0; sample_value = 0;
    cfg_valid = 0; cfg_data = 0; beats_sent = 0;
    send_idle_pct = 33; recv_idle_pct = 73;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed beats at the shortest length
    write_len(7'd2);
    drive_sample(1'b0, 24'h7FFFFF); drive_sample(1'b0, 24'h800000);
    drive_sample(1'b1, 24'h800000); drive_sample(1'b1, 24'h7FFFFF);
    drive_sample(1'b1, 24'h7FFFFF); drive_sample(1'b1, 24'h800000);
    drive_sample(1'b1, 24'd5);      drive_sample(1'b1, 24'd5);
    drive_sample(1'b1, 24'h000000); drive_sample(1'b1, 24'hFFFFFF);
    drive_sample(1'b0, 24'd7);      drive_sample(1'b0, 24'd7);
    drive_sample(1'b1, 24'd1);      drive_sample(1'b1, 24'd2);
    drive_sample(1'b0, 24'd0);      drive_sample(1'b1, 24'h123456);
    drive_sample(1'b0, 24'd1);      drive_sample(1'b1, 24'h800000);
    drive_sample(1'b1, 24'h7FFFFF); drive_sample(1'b1, 24'h000000);
    drive_sample(1'b1, 24'h000000);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 73 : 0;
      recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 33 : 0;
      for (int k = 0; k < 4; k++) begin
        write_len((ph == 2 && k == 3) ? 7'($urandom_range(2, 64)) : lens[(ph * 3 + k) % 8]);
        random_part(150);
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rcc_pkg.sv
hw/rtl/rcc_vec_store.sv
hw/rtl/row_correlation_coefficients_top.sv
test/testbench.sv
